// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define DQSH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define DQSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dqsh_pkg.sv =====
// Package for the DNS query name suffix hasher: types, constants and the hash step.
`default_nettype none

package dqsh_pkg;

    // Default number of suffix accumulators.
    localparam int MAX_LABELS_DEF = 16;

    // Fixed packet layout and name limits.
    localparam int HEADER_BYTES = 12;
    localparam int TYPE_BYTES   = 4;
    localparam int POS_W        = 4;
    localparam logic [8:0] NAME_LIMIT = 9'd250;

    // Field widths and positions on the result stream.
    localparam int HASH_W      = 40;
    localparam int QTYPE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int M_DATA_W    = 64;
    localparam int QTYPE_LSB   = HASH_W;
    localparam int STATUS_LSB  = HASH_W + QTYPE_W;

    // 40-bit FNV-1a constants; the prime is reduced modulo 2^40.
    localparam logic [HASH_W-1:0] FNV_BASIS = 40'he484222325;
    localparam logic [HASH_W-1:0] FNV_PRIME = 40'h00000001b3;

    // Characters of interest.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_CASE    = 8'h20;
    localparam logic [7:0] CH_W       = 8'h77;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    // Progress through a leading "www" label.
    localparam logic [2:0] WWW_FULL = 3'd3;
    localparam logic [2:0] NOT_WWW  = 3'd7;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TYPE   = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    // One FNV-1a step modulo 2^40.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return HASH_W'(x * FNV_PRIME);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dns_qname_suffix_hasher_core.sv =====
// Top level of the DNS query name suffix hasher.
//
// Usage: packet bytes enter on the s_ stream, one byte per word, header first,
// with s_tlast on the final byte. The block skips the 12-byte header, parses the
// first question name and the query type, and keeps one 40-bit FNV-1a hash for
// every label start. After the final byte it sends on the m_ stream the hash of
// the full name and of each parent suffix down to two labels, each with the
// query type; an error, an empty name or too many labels gives one word with
// that status instead. m_tlast marks the final word of a packet.
// Throughput: one byte per cycle, set by the input register feeding the parser
// and the parallel hash lanes, each with a constant multiply.
// Order: the final byte passes the input register and loads the bank count, which
// raises m_tvalid; the results then leave at one word per cycle from a shift bank.
// A final byte waits in the input register while the previous packet's results
// are still draining; other bytes keep flowing.
// Stalls: while m_tready is low the current word holds and the bank keeps its
// contents. Reset clears the parser, the input valid flag and the bank count.
`default_nettype none

module dns_qname_suffix_hasher_core #(
    parameter int MAX_LABELS = dqsh_pkg::MAX_LABELS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // [7:0] data_byte
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    // [39:0] name_hash, [55:40] query_type, [57:56] status, [63:58] zero
    output logic [dqsh_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    input  wire logic                          m_tready
);
    import dqsh_pkg::*;

    localparam int LT_W   = $clog2(MAX_LABELS + 1);
    localparam int AIDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int BANK_N = MAX_LABELS - 1;
    localparam int CNT_W  = $clog2(MAX_LABELS);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [5:0]          left_reg, left_next;
    logic [7:0]          namelen_reg, namelen_next;
    logic [LT_W-1:0]     lt_reg, lt_next;
    logic [QTYPE_W-1:0]  qtype_reg, qtype_next;
    logic [2:0]          www_reg, www_next;
    status_t             err_reg, err_next;

    // Suffix hash lanes.
    logic [HASH_W-1:0]   acc_reg  [MAX_LABELS];
    logic [HASH_W-1:0]   acc_next [MAX_LABELS];

    // Result bank.
    logic [HASH_W-1:0]   bank_hash_reg [BANK_N];
    logic [QTYPE_W-1:0]  bank_qtype_reg;
    status_t             bank_status_reg;
    logic [CNT_W-1:0]    bank_left_reg, bank_left_next;

    // Control for this cycle.
    logic                consume;
    logic                bank_free;
    logic                out_fire;
    logic                absorb_en;
    logic [7:0]          absorb_byte;
    logic                basis_en;
    logic [AIDX_W-1:0]   basis_idx;
    logic [7:0]          lower_byte;
    logic [8:0]          name_sum;
    logic                bank_load;
    status_t             final_status;
    logic [CNT_W-1:0]    final_count;

    // Handshake: a final byte waits until the bank is free.
    assign out_fire  = m_tvalid && m_tready;
    assign bank_free = (bank_left_reg == '0) || (out_fire && m_tlast);
    assign consume   = in_valid_reg && (!in_last_reg || bank_free);
    assign s_tready  = !in_valid_reg || consume;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Byte classification shared by the parser.
    assign lower_byte = ((in_byte_reg >= CH_UPPER_A) && (in_byte_reg <= CH_UPPER_Z)) ?
                        in_byte_reg + CH_CASE : in_byte_reg;
    assign name_sum   = {1'b0, namelen_reg} + {3'b000, in_byte_reg[5:0]} + 9'd1;

    // Parser: one byte per consumed word.
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        left_next    = left_reg;
        namelen_next = namelen_reg;
        lt_next      = lt_reg;
        qtype_next   = qtype_reg;
        www_next     = www_reg;
        err_next     = err_reg;
        absorb_en    = 1'b0;
        absorb_byte  = lower_byte;
        basis_en     = 1'b0;
        basis_idx    = '0;
        if (consume) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (32'(pos_reg) + 1 >= HEADER_BYTES) begin
                        phase_next = PH_LENGTH;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_LENGTH: begin
                    priority if (in_byte_reg == 8'd0) begin
                        phase_next = PH_TYPE;
                        pos_next   = '0;
                    end else if (in_byte_reg[7:6] != 2'b00) begin
                        err_next   = ST_MALFORMED;
                        phase_next = PH_ERROR;
                    end else if (name_sum >= NAME_LIMIT) begin
                        err_next   = ST_MALFORMED;
                        phase_next = PH_ERROR;
                    end else if ((lt_reg != '0) && !((lt_reg == LT_W'(1)) &&
                                 (www_reg == WWW_FULL)) &&
                                 (32'(lt_reg) >= MAX_LABELS)) begin
                        err_next   = ST_OVERFLOW;
                        phase_next = PH_ERROR;
                    end else begin
                        // A new label starts here.
                        if (lt_reg == '0) begin
                            basis_en  = 1'b1;
                            basis_idx = '0;
                            lt_next   = LT_W'(1);
                            www_next  = (in_byte_reg == 8'd3) ? 3'd0 : NOT_WWW;
                        end else if ((lt_reg == LT_W'(1)) && (www_reg == WWW_FULL)) begin
                            // Drop the leading "www" label.
                            basis_en  = 1'b1;
                            basis_idx = '0;
                            www_next  = NOT_WWW;
                        end else begin
                            absorb_en   = 1'b1;
                            absorb_byte = CH_DOT;
                            basis_en    = 1'b1;
                            basis_idx   = AIDX_W'(lt_reg);
                            lt_next     = lt_reg + 1'b1;
                            www_next    = NOT_WWW;
                        end
                        namelen_next = (namelen_reg == 8'd0) ? in_byte_reg : name_sum[7:0];
                        left_next    = in_byte_reg[5:0];
                        phase_next   = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    if ((lt_reg == LT_W'(1)) && (www_reg < WWW_FULL)) begin
                        www_next = (lower_byte == CH_W) ? www_reg + 1'b1 : NOT_WWW;
                    end
                    absorb_en = 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == 6'd1) begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_TYPE: begin
                    if (pos_reg < POS_W'(2)) begin
                        qtype_next = {qtype_reg[7:0], in_byte_reg};
                    end
                    pos_next = pos_reg + 1'b1;
                    if (32'(pos_reg) + 1 >= TYPE_BYTES) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Outcome of the packet on its final byte.
    always_comb begin
        priority if (err_next != ST_OK) begin
            final_status = err_next;
        end else if (phase_next != PH_DONE) begin
            final_status = ST_MALFORMED;
        end else if (lt_next == '0) begin
            final_status = ST_EMPTY;
        end else begin
            final_status = ST_OK;
        end
        final_count = (lt_reg >= LT_W'(2)) ? CNT_W'(lt_reg - 1'b1) : CNT_W'(1);
        if (final_status != ST_OK) begin
            final_count = CNT_W'(1);
        end
    end

    assign bank_load = consume && in_last_reg;

    // Parser registers, cleared at the end of every packet.
    always_ff @(posedge aclk) begin
        if (!aresetn || bank_load) begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            left_reg    <= '0;
            namelen_reg <= '0;
            lt_reg      <= '0;
            qtype_reg   <= '0;
            www_reg     <= '0;
            err_reg     <= ST_OK;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            left_reg    <= left_next;
            namelen_reg <= namelen_next;
            lt_reg      <= lt_next;
            qtype_reg   <= qtype_next;
            www_reg     <= www_next;
            err_reg     <= err_next;
        end
    end

    // Hash lanes: every running lane absorbs the byte, a new lane starts at the basis.
    always_comb begin
        for (int k = 0; k < MAX_LABELS; k++) begin
            acc_next[k] = acc_reg[k];
            if (basis_en && (basis_idx == AIDX_W'(k))) begin
                acc_next[k] = FNV_BASIS;
            end else if (absorb_en && (LT_W'(k) < lt_reg)) begin
                acc_next[k] = fnv_step(acc_reg[k], absorb_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_LABELS; k++) begin
            acc_reg[k] <= acc_next[k];
        end
    end

    // Result bank: loaded on the final byte, shifted one word per transfer.
    always_comb begin
        bank_left_next = bank_left_reg;
        if (bank_load) begin
            bank_left_next = final_count;
        end else if (out_fire) begin
            bank_left_next = bank_left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_left_reg <= '0;
        end else begin
            bank_left_reg <= bank_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bank_load) begin
            for (int j = 0; j < BANK_N; j++) begin
                bank_hash_reg[j] <= (final_status == ST_OK) ? acc_reg[j] : '0;
            end
            bank_qtype_reg  <= (final_status == ST_OK) ? qtype_reg : '0;
            bank_status_reg <= final_status;
        end else if (out_fire) begin
            for (int j = 0; j < BANK_N - 1; j++) begin
                bank_hash_reg[j] <= bank_hash_reg[j + 1];
            end
        end
    end

    // Result stream.
    assign m_tvalid = (bank_left_reg != '0);
    assign m_tlast  = (bank_left_reg == CNT_W'(1));
    assign m_tdata  = {{(M_DATA_W - HASH_W - QTYPE_W - STATUS_W){1'b0}},
                       bank_status_reg, bank_qtype_reg, bank_hash_reg[0]};

endmodule

`default_nettype wire

// ===== rtl/dqsh_checker.sv =====
// Port checker for the DNS query name suffix hasher, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module dqsh_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic [dqsh_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tlast,
    input wire logic                          m_tready
);
    import dqsh_pkg::*;

    logic [STATUS_W-1:0] word_status;
    logic [QTYPE_W-1:0]  word_qtype;
    logic [HASH_W-1:0]   word_hash;

    assign word_status = m_tdata[STATUS_LSB +: STATUS_W];
    assign word_qtype  = m_tdata[QTYPE_LSB +: QTYPE_W];
    assign word_hash   = m_tdata[HASH_W-1:0];

    // A stalled result word stays offered.
    `DQSH_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word withdrawn under stall")

    // A result word with an error status is the final word of its packet.
    `DQSH_ASSERT(a_err_single, aclk, aresetn, m_tvalid && (word_status != ST_OK) |-> m_tlast, "error result is not the final word")

    // A failing packet carries no hash and no type.
    `DQSH_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && (word_status != ST_OK) |-> (word_hash == '0) && (word_qtype == '0), "error result carries payload")

    // Reset empties the result bank.
    `DQSH_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind dns_qname_suffix_hasher_core dqsh_checker u_dqsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready)
);

`default_nettype wire
